[design/mm3_pkg.sv]
// Shared types and constants for the 3x3 fixed-point matrix multiplier.
package mm3_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned IDX_OUT_W = 2;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  // Controller states
  typedef enum logic {
    ST_LOAD,
    ST_COMPUTE
  } mm3_state_e;

  // Shift enables for one storage cell
  typedef struct packed {
    logic a_en;
    logic b_en;
  } mm3_cell_ctrl_t;

  // Tag traveling with each multiply-accumulate step
  typedef struct packed {
    logic                 valid;
    logic                 first;     // first term of a dot product
    logic                 last;      // last term of a dot product
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
    logic                 last_elem; // final element of the product matrix
  } mm3_tag_t;

endpackage

[design/mm3_cell.sv]
// One storage cell of a lane: holds an A word and a B word, shifts toward the lane head.
module mm3_cell (
  input  logic                          clk_i,
  input  mm3_pkg::mm3_cell_ctrl_t       ctrl_i,
  input  logic signed [mm3_pkg::DATA_W-1:0] a_i,
  input  logic signed [mm3_pkg::DATA_W-1:0] b_i,
  output logic signed [mm3_pkg::DATA_W-1:0] a_o,
  output logic signed [mm3_pkg::DATA_W-1:0] b_o
);
  import mm3_pkg::*;

  logic signed [DATA_W-1:0] a_q;
  logic signed [DATA_W-1:0] b_q;

  // A and B words shift independently
  always_ff @(posedge clk_i) begin
    if (ctrl_i.a_en) begin
      a_q <= a_i;
    end
    if (ctrl_i.b_en) begin
      b_q <= b_i;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

[design/mm3_mac.sv]
// Multiply-accumulate unit: 32x32 product, full-width sum, shift and saturate.
module mm3_mac #(
  parameter int unsigned DIM       = 3,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  mm3_pkg::mm3_tag_t                 tag_i,
  input  logic signed [mm3_pkg::DATA_W-1:0] a_i,
  input  logic signed [mm3_pkg::DATA_W-1:0] b_i,
  output logic                              res_valid_o,
  output mm3_pkg::mm3_tag_t                 res_tag_o,
  output logic        [mm3_pkg::DATA_W-1:0] res_data_o
);
  import mm3_pkg::*;

  localparam int unsigned ACC_W = PROD_W + $clog2(DIM);

  mm3_tag_t                 prod_tag_q;
  logic signed [PROD_W-1:0] prod_q;
  mm3_tag_t                 acc_tag_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_sh;
  logic                     fits;

  // Tag pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_tag_q <= '0;
      acc_tag_q  <= '0;
    end else if (en_i) begin
      prod_tag_q <= tag_i;
      acc_tag_q  <= prod_tag_q;
    end
  end

  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // Multiply, then accumulate
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
      if (prod_tag_q.valid) begin
        acc_q <= prod_tag_q.first ? prod_ext : acc_q + prod_ext;
      end
    end
  end

  // Arithmetic shift (floor), then saturate to 32 bits
  always_comb begin
    acc_sh = acc_q >>> FRAC_BITS;
    fits   = (&acc_sh[ACC_W-1:DATA_W-1]) || (~|acc_sh[ACC_W-1:DATA_W-1]);
    if (fits) begin
      res_data_o = acc_sh[DATA_W-1:0];
    end else begin
      res_data_o = acc_sh[ACC_W-1] ? SAT_MIN : SAT_MAX;
    end
  end

  assign res_valid_o = acc_tag_q.valid && acc_tag_q.last;
  assign res_tag_o   = acc_tag_q;

endmodule

[design/matrix_multiply_3x3.sv]
// Top level: lanes of storage cells, issue sequencer, MAC pipeline and output register.
//
// Usage: multiplies two DIM x DIM matrices in signed fixed point (FRAC_BITS fraction bits).
// Input channel (in_valid_i / in_stall_o) carries one element of A and one of B per
// transfer, both row-major. in_stall_o is high while the block works on a loaded pair.
// After the DIM*DIM-th transfer, the product is computed on a single shared multiplier,
// one multiply-accumulate per cycle unless out_stall_i holds a full output register.
// Output channel (out_valid_o / out_stall_i) delivers DIM*DIM results row-major with row,
// column and a last mark on the final element. Each result passes the operand registers,
// the product register and the accumulator before it is registered in the output register.
// One result is produced per DIM multiply-accumulates. A new pair cannot be loaded until
// the last multiply-accumulate of the current pair has been issued.
// Each output is the full-width sum of DIM products, shifted right by FRAC_BITS
// (rounding toward minus infinity) and saturated to 32 bits.
// Out_stall_i freezes the compute sequencer and MAC pipeline while the output register
// is full; nothing is lost. Loading of the next pair may overlap draining results.
// Reset (asynchronous, active low) empties the pipeline and returns to loading at element 0.
module matrix_multiply_3x3 #(
  parameter int unsigned DIM       = 3,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] a_element_i,
  input  logic [31:0] b_element_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] product_element_o,
  output logic [1:0]  out_row_o,
  output logic [1:0]  out_col_o,
  output logic        last_element_o
);
  import mm3_pkg::*;

  localparam int unsigned IDX_W = $clog2(DIM);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

  mm3_state_e state_q, state_d;

  logic [IDX_W-1:0] load_row_q, load_row_d;
  logic [IDX_W-1:0] load_col_q, load_col_d;
  logic [IDX_W-1:0] r_q, r_d;
  logic [IDX_W-1:0] c_q, c_d;
  logic [IDX_W-1:0] i_q, i_d;

  logic load_fire;
  logic loading;
  logic en;
  logic issue;
  logic issue_done;

  logic signed [DATA_W-1:0] a_head [DIM];
  logic signed [DATA_W-1:0] b_head [DIM];

  mm3_tag_t                 issue_tag;
  mm3_tag_t                 op_tag_q;
  logic signed [DATA_W-1:0] op_a_q;
  logic signed [DATA_W-1:0] op_b_q;

  logic                     res_valid;
  mm3_tag_t                 res_tag;
  logic        [DATA_W-1:0] res_data;

  logic                     out_valid_q;
  logic        [DATA_W-1:0] product_q;
  logic [IDX_OUT_W-1:0]     row_q;
  logic [IDX_OUT_W-1:0]     col_q;
  logic                     last_q;

  // Handshake and pipeline enable
  assign loading    = (state_q == ST_LOAD);
  assign in_stall_o = !loading;
  assign load_fire  = in_valid_i && !in_stall_o;
  assign en         = !(out_valid_q && out_stall_i);
  assign issue      = (state_q == ST_COMPUTE) && en;
  assign issue_done = (r_q == IDX_LAST) && (c_q == IDX_LAST) && (i_q == IDX_LAST);

  // Storage lanes: lane l holds row l of A and column l of B
  for (genvar l = 0; l < DIM; l++) begin : g_lane
    logic signed [DATA_W-1:0] a_chain [DIM+1];
    logic signed [DATA_W-1:0] b_chain [DIM+1];
    mm3_cell_ctrl_t           ctrl;

    assign ctrl.a_en = (load_fire && (load_row_q == IDX_W'(l))) ||
                       (issue && (r_q == IDX_W'(l)));
    assign ctrl.b_en = (load_fire && (load_col_q == IDX_W'(l))) ||
                       (issue && (c_q == IDX_W'(l)));

    // Tail takes new data while loading, the head word while rotating
    assign a_chain[DIM] = loading ? a_element_i : a_chain[0];
    assign b_chain[DIM] = loading ? b_element_i : b_chain[0];

    for (genvar j = 0; j < DIM; j++) begin : g_cell
      mm3_cell u_cell (
        .clk_i  (clk_i),
        .ctrl_i (ctrl),
        .a_i    (a_chain[j+1]),
        .b_i    (b_chain[j+1]),
        .a_o    (a_chain[j]),
        .b_o    (b_chain[j])
      );
    end

    assign a_head[l] = a_chain[0];
    assign b_head[l] = b_chain[0];
  end

  // Controller and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_row_q <= '0;
      load_col_q <= '0;
      r_q        <= '0;
      c_q        <= '0;
      i_q        <= '0;
    end else begin
      state_q    <= state_d;
      load_row_q <= load_row_d;
      load_col_q <= load_col_d;
      r_q        <= r_d;
      c_q        <= c_d;
      i_q        <= i_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    load_row_d = load_row_q;
    load_col_d = load_col_q;
    r_d        = r_q;
    c_d        = c_q;
    i_d        = i_q;
    unique case (state_q)
      ST_LOAD: begin
        if (load_fire) begin
          if (load_col_q == IDX_LAST) begin
            load_col_d = '0;
            if (load_row_q == IDX_LAST) begin
              load_row_d = '0;
              state_d    = ST_COMPUTE;
            end else begin
              load_row_d = load_row_q + IDX_W'(1);
            end
          end else begin
            load_col_d = load_col_q + IDX_W'(1);
          end
        end
      end
      ST_COMPUTE: begin
        if (issue) begin
          if (i_q == IDX_LAST) begin
            i_d = '0;
            if (c_q == IDX_LAST) begin
              c_d = '0;
              r_d = (r_q == IDX_LAST) ? '0 : r_q + IDX_W'(1);
            end else begin
              c_d = c_q + IDX_W'(1);
            end
          end else begin
            i_d = i_q + IDX_W'(1);
          end
          if (issue_done) begin
            state_d = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Operand registers: heads of the selected A and B lanes
  always_comb begin
    issue_tag.valid     = (state_q == ST_COMPUTE);
    issue_tag.first     = (i_q == '0);
    issue_tag.last      = (i_q == IDX_LAST);
    issue_tag.row       = IDX_OUT_W'(r_q);
    issue_tag.col       = IDX_OUT_W'(c_q);
    issue_tag.last_elem = (r_q == IDX_LAST) && (c_q == IDX_LAST);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_tag_q <= '0;
    end else if (en) begin
      op_tag_q <= issue_tag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op_a_q <= a_head[r_q];
      op_b_q <= b_head[c_q];
    end
  end

  mm3_mac #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .tag_i       (op_tag_q),
    .a_i         (op_a_q),
    .b_i         (op_b_q),
    .res_valid_o (res_valid),
    .res_tag_o   (res_tag),
    .res_data_o  (res_data)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && res_valid) begin
      product_q <= res_data;
      row_q     <= res_tag.row;
      col_q     <= res_tag.col;
      last_q    <= res_tag.last_elem;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign product_element_o = product_q;
  assign out_row_o         = row_q;
  assign out_col_o         = col_q;
  assign last_element_o    = last_q;

  // Last mark only on the bottom-right element
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_element_o |->
      out_row_o == IDX_OUT_W'(DIM - 1) && out_col_o == IDX_OUT_W'(DIM - 1))
    else $error("last mark on wrong element");

  // Compute starts only with a complete load
  a_load_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_COMPUTE) |-> load_row_q == '0 && load_col_q == '0)
    else $error("compute started with partial load");

  // Issue counters rest at zero while loading
  a_issue_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> r_q == '0 && c_q == '0 && i_q == '0)
    else $error("issue counters not cleared");

  // A held result is never overwritten
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(product_q) && $stable(last_q))
    else $error("stalled result changed");

endmodule

[tb/testbench.sv]
// Self-checking testbench for the 3x3 fixed-point matrix multiplier.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mm3_pkg::*;

  localparam int unsigned DIM             = 3;
  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned CELLS           = DIM * DIM;
  localparam int unsigned NUM_PHASES      = 5;
  localparam int unsigned ITEMS_PER_PHASE = 63;
  localparam int unsigned HOLD_CYCLES     = 150;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;

  localparam logic [DATA_W-1:0] Q_ONE     = 32'h0001_0000;
  localparam logic [DATA_W-1:0] Q_NEG_ONE = 32'hffff_0000;

  // Bounds of a representable result after the fraction shift
  localparam logic signed [65:0] SUM_MAX = 66'sh7fff_ffff;
  localparam logic signed [65:0] SUM_MIN = -66'sh8000_0000;

  typedef struct {
    logic [DATA_W-1:0] value;
    logic [1:0]        row;
    logic [1:0]        col;
    logic              last;
  } product_t;

  // Holds both loaded matrices and the queue of products still owed by the block
  class product_scoreboard;
    logic signed [DATA_W-1:0] a_cells[CELLS];
    logic signed [DATA_W-1:0] b_cells[CELLS];
    int unsigned              loaded;
    product_t                 expected_q[$];
    int unsigned              errors;

    function new();
      loaded = 0;
      errors = 0;
    endfunction

    // Store one element pair; on the ninth, queue the full product matrix
    function void note_input(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      logic signed [65:0] sum;
      logic signed [65:0] scaled;
      product_t           p;
      a_cells[loaded] = a;
      b_cells[loaded] = b;
      loaded++;
      if (loaded < CELLS) return;
      loaded = 0;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          sum = '0;
          for (int i = 0; i < DIM; i++) begin
            sum = sum + a_cells[r * DIM + i] * b_cells[i * DIM + c];
          end
          // arithmetic shift floors toward minus infinity, then clamp
          scaled = sum >>> FRAC_BITS;
          if (scaled > SUM_MAX) begin
            p.value = SAT_MAX;
          end else if (scaled < SUM_MIN) begin
            p.value = SAT_MIN;
          end else begin
            p.value = scaled[DATA_W-1:0];
          end
          p.row  = 2'(r);
          p.col  = 2'(c);
          p.last = (r == DIM - 1) && (c == DIM - 1);
          expected_q.push_back(p);
        end
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Compare one delivered product against the oldest one owed
    function void check_result(product_t got);
      product_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected product, expected none, actual %0h row %0d col %0d",
                 $time, got.value, got.row, got.col);
        return;
      end
      want = expected_q.pop_front();
      compare_field("product_element", want.value, got.value);
      compare_field("out_row", 32'(want.row), 32'(got.row));
      compare_field("out_col", 32'(want.col), 32'(got.col));
      compare_field("last_element", 32'(want.last), 32'(got.last));
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic [DATA_W-1:0] a_element_i = '0;
  logic [DATA_W-1:0] b_element_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DATA_W-1:0] product_element_o;
  logic [1:0]        out_row_o;
  logic [1:0]        out_col_o;
  logic              last_element_o;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;

  product_scoreboard sb = new();

  matrix_multiply_3x3 #(
    .DIM      (DIM),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .a_element_i      (a_element_i),
    .b_element_i      (b_element_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .product_element_o(product_element_o),
    .out_row_o        (out_row_o),
    .out_col_o        (out_col_o),
    .last_element_o   (last_element_o)
  );

  always #10 clk_i = ~clk_i;

  // Offer one element pair, with random idle cycles ahead, and wait for the transfer
  task automatic send_pair(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    a_element_i <= a;
    b_element_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(a, b);
  endtask

  // Mix of boundary values, full-range noise and modest Q15.16 magnitudes
  function automatic logic [DATA_W-1:0] rand_element();
    case ($urandom_range(9))
      0: return SAT_MAX;
      1: return SAT_MIN;
      2: return '0;
      3, 4, 5: return $urandom();
      default: return 32'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  // Result side: check transfers, then pick next cycle's stall
  initial begin
    product_t got;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.value = product_element_o;
        got.row   = out_row_o;
        got.col   = out_col_o;
        got.last  = last_element_o;
        sb.check_result(got);
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: too long without any transfer on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench: done, errors");
    $finish;
  end

  // Stimulus
  initial begin
    logic [DATA_W-1:0] boundary_b[CELLS];
    int unsigned       send_by_phase[NUM_PHASES];
    int unsigned       stall_by_phase[NUM_PHASES];
    boundary_b     = '{SAT_MAX, SAT_MIN, 32'h0, 32'hffff_ffff, 32'h1,
                       Q_ONE, Q_NEG_ONE, 32'h5555_5555, 32'haaaa_aaaa};
    send_by_phase  = '{0, 77, 0, 8, 0};
    stall_by_phase = '{0, 0, 77, 8, 0};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // identity times boundary values: exact pass-through
    for (int k = 0; k < CELLS; k++) begin
      send_pair((k % (DIM + 1) == 0) ? Q_ONE : '0, boundary_b[k]);
    end
    // rows of max / min / -1 lsb against columns of max / min / +1 lsb:
    // both saturations, widest sums, and flooring of a small negative
    for (int k = 0; k < CELLS; k++) begin
      send_pair((k / DIM == 0) ? SAT_MAX : (k / DIM == 1) ? SAT_MIN : 32'hffff_ffff,
                (k % DIM == 0) ? SAT_MAX : (k % DIM == 1) ? SAT_MIN : 32'h1);
    end
    // negated identity: negating the most negative value saturates
    for (int k = 0; k < CELLS; k++) begin
      send_pair((k % (DIM + 1) == 0) ? Q_NEG_ONE : '0, boundary_b[k]);
    end

    // random matrices under changing idle patterns; first phase starts with a long hold-off
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = send_by_phase[ph];
      recv_stall_pct = stall_by_phase[ph];
      if (ph == 0) hold_left = HOLD_CYCLES;
      repeat (ITEMS_PER_PHASE) send_pair(rand_element(), rand_element());
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
